// ===== sv/pin_entry_lock_controller_assert.svh =====
// assertion macros for the pin entry lock controller
// used by the top level only, needs nothing else
`ifndef PIN_ENTRY_LOCK_CONTROLLER_ASSERT_SVH
`define PIN_ENTRY_LOCK_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PEL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pel assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pel assertion failed");

`endif

// ===== sv/pel_pkg.sv =====
// shared codes, constants and structs of the pin entry lock controller
// no dependencies
`timescale 1ns / 1ps

package pel_pkg;

    // action codes of an input transaction
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_BEGIN   = 3'd1;
    localparam logic [2:0] ACT_DOWN    = 3'd2;
    localparam logic [2:0] ACT_UP      = 3'd3;
    localparam logic [2:0] ACT_CONFIRM = 3'd4;
    localparam logic [2:0] ACT_CANCEL  = 3'd5;
    localparam logic [2:0] ACT_SERIAL  = 3'd6;

    // result codes
    localparam logic [2:0] EV_UNLOCKED      = 3'd0;
    localparam logic [2:0] EV_WRONG_PIN     = 3'd1;
    localparam logic [2:0] EV_LOCKOUT_OVER  = 3'd2;
    localparam logic [2:0] EV_CANCELLED     = 3'd3;
    localparam logic [2:0] EV_PIN_SAVED     = 3'd4;
    localparam logic [2:0] EV_CHANGE_CANCEL = 3'd5;
    localparam logic [2:0] EV_SERIAL_TMO    = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_SERIAL_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_LOCKOUT        = 2'd1;
    localparam logic [1:0] CFG_MAX_ATTEMPTS   = 2'd2;

    localparam logic [15:0] SERIAL_TIMEOUT_RST = 16'd30000;
    localparam logic [15:0] LOCKOUT_RST        = 16'd30000;
    localparam logic [2:0]  MAX_ATTEMPTS_RST   = 3'd3;

    // characters
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_BUTTONS = 3'd1,
        MODE_SERIAL  = 3'd2,
        MODE_LOCKOUT = 3'd3,
        MODE_CHANGE  = 3'd4
    } mode_t;

    typedef struct packed {
        logic [15:0] serial_timeout_ticks;
        logic [15:0] lockout_ticks;
        logic [2:0]  max_attempts;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] action;
        logic [7:0] serial_byte;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] event_res;
        logic [2:0] attempts_left;
    } res_t;

endpackage

// ===== sv/pel_in_if.sv =====
// input channel of the pin entry lock controller: events
// no dependencies
`timescale 1ns / 1ps

interface pel_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] serial_byte;

    modport source (output valid, output action, output serial_byte, input ready);
    modport sink   (input valid, input action, input serial_byte, output ready);
endinterface

// ===== sv/pel_out_if.sv =====
// output channel of the pin entry lock controller: results
// no dependencies
`timescale 1ns / 1ps

interface pel_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [2:0] attempts_left;

    modport source (output valid, output event_res, output attempts_left, input ready);
    modport sink   (input valid, input event_res, input attempts_left, output ready);
endinterface

// ===== sv/pel_cfg.sv =====
// configuration registers of the pin entry lock controller
// depends on pel_pkg
`timescale 1ns / 1ps

module pel_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    output pel_pkg::cfg_t      cfg
);

    pel_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.serial_timeout_ticks <= pel_pkg::SERIAL_TIMEOUT_RST;
            cfg_reg.lockout_ticks        <= pel_pkg::LOCKOUT_RST;
            cfg_reg.max_attempts         <= pel_pkg::MAX_ATTEMPTS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pel_pkg::CFG_SERIAL_TIMEOUT: cfg_reg.serial_timeout_ticks <= cfg_wdata;
                pel_pkg::CFG_LOCKOUT:        cfg_reg.lockout_ticks        <= cfg_wdata;
                pel_pkg::CFG_MAX_ATTEMPTS:   cfg_reg.max_attempts         <= cfg_wdata[2:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/pel_in_reg.sv =====
// input register stage: holds one event transaction until the core takes it
// depends on pel_pkg and pel_in_if
`timescale 1ns / 1ps

module pel_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    pel_in_if.sink          in_ch,
    input  logic            advance,
    output pel_pkg::item_t  item
);

    logic       valid_reg;
    logic [2:0] action_reg;
    logic [7:0] byte_reg;

    // free when empty or when the held item leaves this cycle
    assign in_ch.ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            action_reg <= in_ch.action;
            byte_reg   <= in_ch.serial_byte;
        end
    end

    assign item.valid       = valid_reg;
    assign item.action      = action_reg;
    assign item.serial_byte = byte_reg;

endmodule

// ===== sv/pel_core.sv =====
// lock state machine: mode, stored pin, entry digits, counters
// depends on pel_pkg
`timescale 1ns / 1ps

module pel_core #(
    parameter int PIN_DIGITS = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  pel_pkg::item_t  item,
    input  pel_pkg::cfg_t   cfg,
    output pel_pkg::res_t   res
);

    localparam int POS_W = $clog2(PIN_DIGITS + 1);
    localparam int IDX_W = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
    localparam logic [POS_W-1:0] POS_END = POS_W'(PIN_DIGITS);

    pel_pkg::mode_t   mode_reg, mode_next;
    logic [3:0]       stored_reg [PIN_DIGITS];
    logic [3:0]       entry_reg  [PIN_DIGITS];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       sel_reg, sel_next;
    logic [2:0]       attempt_reg, attempt_next;
    logic [15:0]      tick_reg, tick_next;
    logic             store_pin;

    logic             act_tick, act_serial, act_confirm;
    logic             in_buttons, in_serial_mode;
    logic             digit_char, filler;
    logic [3:0]       digit_val;
    logic [7:0]       digit_diff;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [3:0]       wr_data;
    logic [3:0]       merged [PIN_DIGITS];
    logic             match;
    logic [POS_W-1:0] pos_inc;
    logic             done;
    logic [2:0]       attempt_inc;
    logic             lock;
    logic [2:0]       tries;
    logic             serial_tmo;
    logic [15:0]      lock_tick;
    logic             lock_end;
    pel_pkg::mode_t   finish_mode;

    assign act_tick       = item.action == pel_pkg::ACT_TICK;
    assign act_serial     = item.action == pel_pkg::ACT_SERIAL;
    assign act_confirm    = item.action == pel_pkg::ACT_CONFIRM;
    assign in_buttons     = mode_reg == pel_pkg::MODE_BUTTONS;
    assign in_serial_mode = mode_reg == pel_pkg::MODE_SERIAL
                         || mode_reg == pel_pkg::MODE_CHANGE;

    assign digit_char = item.serial_byte >= pel_pkg::CHAR_ZERO
                     && item.serial_byte <= pel_pkg::CHAR_NINE;
    assign filler     = item.serial_byte == pel_pkg::CHAR_NL
                     || item.serial_byte == pel_pkg::CHAR_CR
                     || item.serial_byte == pel_pkg::CHAR_SPACE
                     || item.serial_byte == pel_pkg::CHAR_TAB
                     || item.serial_byte == pel_pkg::CHAR_STAR;
    assign digit_diff = item.serial_byte - pel_pkg::CHAR_ZERO;
    assign digit_val  = digit_diff[3:0];

    // entry digit write for this event, merged ahead of the compare
    assign wr_en   = (in_buttons && act_confirm && pos_reg < POS_END)
                  || (in_buttons && act_serial && digit_char)
                  || (in_serial_mode && act_serial && digit_char && pos_reg < POS_END);
    assign wr_idx  = (in_buttons && act_serial) ? '0 : pos_reg[IDX_W-1:0];
    assign wr_data = (in_buttons && act_confirm) ? sel_reg : digit_val;

    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < PIN_DIGITS; i++)
        begin
            merged[i] = (wr_en && wr_idx == IDX_W'(i)) ? wr_data : entry_reg[i];
            if (merged[i] != stored_reg[i])
            begin
                match = 1'b0;
            end
        end
    end

    assign pos_inc     = (in_buttons && act_serial) ? POS_W'(1) : pos_reg + POS_W'(1);
    assign done        = pos_inc >= POS_END;
    assign attempt_inc = attempt_reg + 3'd1;
    assign lock        = attempt_inc >= cfg.max_attempts;
    assign tries       = cfg.max_attempts - attempt_inc;
    assign serial_tmo  = tick_reg >= cfg.serial_timeout_ticks;
    assign lock_tick   = tick_reg + 16'd1;
    assign lock_end    = lock_tick >= cfg.lockout_ticks;
    assign finish_mode = match ? pel_pkg::MODE_IDLE
                       : (lock ? pel_pkg::MODE_LOCKOUT : pel_pkg::MODE_BUTTONS);

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            pel_pkg::MODE_IDLE:
            begin
                if (item.action == pel_pkg::ACT_BEGIN)
                begin
                    mode_next = pel_pkg::MODE_BUTTONS;
                end
                else if (act_serial && item.serial_byte == pel_pkg::CHAR_STAR)
                begin
                    mode_next = pel_pkg::MODE_CHANGE;
                end
            end
            pel_pkg::MODE_BUTTONS:
            begin
                if (act_confirm && done)
                begin
                    mode_next = finish_mode;
                end
                else if (item.action == pel_pkg::ACT_CANCEL)
                begin
                    mode_next = pel_pkg::MODE_IDLE;
                end
                else if (act_serial)
                begin
                    mode_next = (digit_char && done) ? finish_mode : pel_pkg::MODE_SERIAL;
                end
            end
            pel_pkg::MODE_SERIAL, pel_pkg::MODE_CHANGE:
            begin
                if (act_tick && serial_tmo)
                begin
                    mode_next = (mode_reg == pel_pkg::MODE_SERIAL)
                              ? pel_pkg::MODE_BUTTONS : pel_pkg::MODE_IDLE;
                end
                else if (act_serial && digit_char && done)
                begin
                    mode_next = (mode_reg == pel_pkg::MODE_SERIAL)
                              ? finish_mode : pel_pkg::MODE_IDLE;
                end
            end
            pel_pkg::MODE_LOCKOUT:
            begin
                if (act_tick && lock_end)
                begin
                    mode_next = pel_pkg::MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = pel_pkg::MODE_IDLE;
            end
        endcase
    end

    // counters, pin store and result
    always_comb
    begin
        pos_next          = pos_reg;
        sel_next          = sel_reg;
        attempt_next      = attempt_reg;
        tick_next         = tick_reg;
        store_pin         = 1'b0;
        res.valid         = 1'b0;
        res.event_res     = pel_pkg::EV_UNLOCKED;
        res.attempts_left = 3'd0;
        unique case (mode_reg)
            pel_pkg::MODE_IDLE:
            begin
                if (item.action == pel_pkg::ACT_BEGIN)
                begin
                    attempt_next = 3'd0;
                    pos_next     = '0;
                    sel_next     = 4'd0;
                end
                else if (act_serial && item.serial_byte == pel_pkg::CHAR_STAR)
                begin
                    pos_next  = '0;
                    tick_next = 16'd0;
                end
            end
            pel_pkg::MODE_BUTTONS:
            begin
                unique case (item.action)
                    pel_pkg::ACT_DOWN:
                    begin
                        sel_next = (sel_reg == 4'd0) ? 4'd9 : sel_reg - 4'd1;
                    end
                    pel_pkg::ACT_UP:
                    begin
                        sel_next = (sel_reg >= 4'd9) ? 4'd0 : sel_reg + 4'd1;
                    end
                    pel_pkg::ACT_CONFIRM:
                    begin
                        pos_next = pos_inc;
                        sel_next = 4'd0;
                    end
                    pel_pkg::ACT_CANCEL:
                    begin
                        pos_next      = '0;
                        sel_next      = 4'd0;
                        res.valid     = 1'b1;
                        res.event_res = pel_pkg::EV_CANCELLED;
                    end
                    pel_pkg::ACT_SERIAL:
                    begin
                        pos_next  = digit_char ? pos_inc : '0;
                        tick_next = 16'd0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            pel_pkg::MODE_SERIAL, pel_pkg::MODE_CHANGE:
            begin
                if (act_tick)
                begin
                    if (serial_tmo)
                    begin
                        res.valid = 1'b1;
                        pos_next  = '0;
                        if (mode_reg == pel_pkg::MODE_SERIAL)
                        begin
                            sel_next      = 4'd0;
                            res.event_res = pel_pkg::EV_SERIAL_TMO;
                        end
                        else
                        begin
                            res.event_res = pel_pkg::EV_CHANGE_CANCEL;
                        end
                    end
                    else
                    begin
                        tick_next = tick_reg + 16'd1;
                    end
                end
                else if (act_serial)
                begin
                    if (digit_char)
                    begin
                        pos_next  = pos_inc;
                        tick_next = 16'd0;
                        if (done && mode_reg == pel_pkg::MODE_CHANGE)
                        begin
                            store_pin     = 1'b1;
                            pos_next      = '0;
                            res.valid     = 1'b1;
                            res.event_res = pel_pkg::EV_PIN_SAVED;
                        end
                    end
                    else if (filler)
                    begin
                        tick_next = 16'd0;
                    end
                end
            end
            pel_pkg::MODE_LOCKOUT:
            begin
                if (act_tick)
                begin
                    tick_next = lock_tick;
                    if (lock_end)
                    begin
                        pos_next      = '0;
                        sel_next      = 4'd0;
                        tick_next     = 16'd0;
                        res.valid     = 1'b1;
                        res.event_res = pel_pkg::EV_LOCKOUT_OVER;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // pin compare once the last digit of an unlock entry is in
        if (done && ((in_buttons && act_confirm)
                  || (in_buttons && act_serial && digit_char)
                  || (mode_reg == pel_pkg::MODE_SERIAL && act_serial && digit_char)))
        begin
            res.valid = 1'b1;
            if (match)
            begin
                pos_next      = '0;
                sel_next      = 4'd0;
                res.event_res = pel_pkg::EV_UNLOCKED;
            end
            else
            begin
                attempt_next  = attempt_inc;
                res.event_res = pel_pkg::EV_WRONG_PIN;
                if (lock)
                begin
                    tick_next = 16'd0;
                end
                else
                begin
                    pos_next          = '0;
                    sel_next          = 4'd0;
                    res.attempts_left = tries;
                end
            end
        end

        if (!go)
        begin
            res.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= pel_pkg::MODE_IDLE;
            pos_reg     <= '0;
            sel_reg     <= 4'd0;
            attempt_reg <= 3'd0;
            tick_reg    <= 16'd0;
            for (int i = 0; i < PIN_DIGITS; i++)
            begin
                stored_reg[i] <= 4'd0;
            end
        end
        else if (go)
        begin
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            sel_reg     <= sel_next;
            attempt_reg <= attempt_next;
            tick_reg    <= tick_next;
            if (store_pin)
            begin
                for (int i = 0; i < PIN_DIGITS; i++)
                begin
                    stored_reg[i] <= merged[i];
                end
            end
        end
    end

    // entry digits carry no reset
    always_ff @(posedge clk)
    begin
        if (go && wr_en)
        begin
            entry_reg[wr_idx] <= wr_data;
        end
    end

endmodule

// ===== sv/pel_out_reg.sv =====
// result register: holds one result transaction until the sink takes it
// depends on pel_pkg and pel_out_if
`timescale 1ns / 1ps

module pel_out_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  pel_pkg::res_t  res,
    output logic           free,
    pel_out_if.source      out_ch
);

    logic       valid_reg;
    logic [2:0] event_reg;
    logic [2:0] tries_reg;

    assign free = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && res.valid)
        begin
            event_reg <= res.event_res;
            tries_reg <= res.attempts_left;
        end
    end

    assign out_ch.valid         = valid_reg;
    assign out_ch.event_res     = event_reg;
    assign out_ch.attempts_left = tries_reg;

endmodule

// ===== sv/pin_entry_lock_controller.sv =====
// pin entry lock: an accepted input transaction passes the input register and the core,
// and its result then waits in the result register
// throughput one event per cycle; a stalled result register holds the core, and the input
// register then holds one more event before ready drops
// reset (rst_n, async, active low): mode idle, stored pin 0000, counters zero,
// registers 30000 / 30000 / 3, both channel stages empty
`timescale 1ns / 1ps
`include "pin_entry_lock_controller_assert.svh"

module pin_entry_lock_controller #(
    parameter int PIN_DIGITS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    pel_in_if.sink      in_ch,
    pel_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    pel_pkg::cfg_t  cfg;
    pel_pkg::item_t item;
    pel_pkg::res_t  res;
    logic           out_free;
    logic           core_go;
    logic           tries_shown;
    logic           wrong_pin_shown;

    // the core handles the held event only when the result register can take
    // whatever result it makes; events with no result go through the same way
    assign core_go = item.valid && out_free;

    // configuration registers; the user must write them only while the block is idle, the block does not enforce this
    pel_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input register: one transaction in flight toward the core
    pel_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .advance (core_go),
        .item    (item)
    );

    // mode machine, pin store and counters, one event per cycle while the result register is free
    pel_core #(
        .PIN_DIGITS (PIN_DIGITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (core_go),
        .item  (item),
        .cfg   (cfg),
        .res   (res)
    );

    // result register parting the core from the sink
    pel_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .res    (res),
        .free   (out_free),
        .out_ch (out_ch)
    );

    // terms for the checks below
    assign tries_shown     = out_ch.valid && out_ch.attempts_left != 3'd0;
    assign wrong_pin_shown = out_ch.event_res == pel_pkg::EV_WRONG_PIN;

    // an empty result register never backs up the input side
    `PEL_ASSERT_NOW(a_ready_when_out_empty, clk, rst_n, !out_ch.valid, in_ch.ready)

    // a new result only appears after the core handled an event
    `PEL_ASSERT_NEXT(a_result_from_core, clk, rst_n, !out_ch.valid && !core_go, !out_ch.valid)

    // attempts left is nonzero only on a wrong pin
    `PEL_ASSERT_NOW(a_tries_only_wrong, clk, rst_n, tries_shown, wrong_pin_shown)

endmodule
